@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/upl_pkg.sv @@
package upl_pkg;

  localparam int DATA_W          = 8;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int FLEN_W          = POS_W + 1;
  localparam int STATUS_W        = 3;
  localparam int OFFSET_W        = 7;
  localparam int PLEN_W          = 16;
  localparam int SUM_W           = 17;

  localparam int IP_START      = 14;
  localparam int PROTO_POS     = 23;
  localparam int LEN_POS_BASE  = 18;  // IP_START + 4
  localparam int PAYLOAD_BASE  = 22;  // IP_START + 8
  localparam int UDP_HDR       = 8;
  localparam int MIN_FRAME     = 42;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_UDP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PAYLOAD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd4;

  // Everything the back end needs to judge one frame.
  typedef struct packed {
    logic [FLEN_W-1:0] frame_len;
    logic [3:0]        header_words;
    logic [7:0]        protocol;
    logic [15:0]       udp_len;
    logic              len_captured;
  } frame_sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/upl_in_if.sv @@
interface upl_in_if import upl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/upl_out_if.sv @@
interface upl_out_if import upl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] payload_offset;
  logic [PLEN_W-1:0]   payload_len;

  modport source (output valid, output status, output payload_offset,
                  output payload_len, input ready);
  modport sink   (input valid, input status, input payload_offset,
                  input payload_len, output ready);
endinterface

@@ design/udp_payload_locator_top.sv @@
// Ethernet/IPv4/UDP payload locator. Frame bytes enter on in_word in wire order,
// one word per byte, with last_byte set on the final byte. For every frame one
// result word leaves on out_word: status (ok, too short, not UDP, no payload, bad
// length), and when ok the payload byte offset (22 + 4*IHL) and length (UDP
// length - 8). Ethertype and IP version are not checked; a UDP frame of at least
// MIN_FRAME bytes that ends before the UDP length field is reported as bad length.
// The block takes one byte per clock while in_word.ready is high, bursts
// included. out_word.valid rises after the edge that accepts the last byte, when
// the output register is free: the front end hands a per-frame summary to a
// two-entry queue, the back end judges it and registers the result. in_word.ready
// drops only when the queue holds two unjudged frames because out_word is stalled;
// the single judging stage and the output register set that limit.
`include "assert_macros.svh"

module udp_payload_locator_top import upl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  upl_in_if.sink     in_word,
  upl_out_if.source  out_word
);

  // front end -> queue
  logic       push;
  frame_sum_t push_sum;

  // queue -> back end
  logic       pop;
  frame_sum_t pop_sum;
  q_status_t  q_stat;

  // ok result on the output, and its fields in range
  logic       ok_shown;
  logic       ok_fit;

  // byte counting and field capture
  upl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .push     (push),
    .push_sum (push_sum)
  );

  // decouples frame ends from the output stall
  upl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_sum (push_sum),
    .pop      (pop),
    .pop_sum  (pop_sum),
    .q_stat   (q_stat)
  );

  // classification and output register
  upl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_sum  (pop_sum),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_word (out_word)
  );

  assign ok_shown = out_word.valid && (out_word.status == ST_OK);
  assign ok_fit   = (out_word.payload_offset >= OFFSET_W'(PAYLOAD_BASE)) &&
                    (out_word.payload_len != '0);

  // a frame end never lands on a full queue
  `ASSERT_IMPL(a_no_overflow, push, !q_stat.full)
  // a pushed summary is held until judged
  `ASSERT_NEXT(a_push_lands, push, !q_stat.empty)
  // every judged frame shows up on the output
  `ASSERT_NEXT(a_pop_shows, pop, out_word.valid)
  // an ok result always points past the UDP header with a nonempty payload
  `ASSERT_IMPL(a_ok_fields, ok_shown, ok_fit)

endmodule

@@ design/upl_front.sv @@
module upl_front import upl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  upl_in_if.sink     in_word,
  input  q_status_t  q_stat,
  output logic       push,
  output frame_sum_t push_sum
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        hw_r, hw_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [15:0]       udp_r, udp_nxt;
  logic              cap_r, cap_nxt;

  logic              accept;
  logic [FLEN_W-1:0] pos_ext;
  logic [FLEN_W-1:0] len_pos;
  logic [3:0]        hw_cur;
  logic [7:0]        proto_cur;
  logic [15:0]       udp_cur;
  logic              hi_hit, lo_hit;

  assign in_word.ready = !q_stat.full;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    pos_ext   = FLEN_W'(pos_r);
    hw_cur    = (pos_ext == FLEN_W'(IP_START)) ? in_word.data_byte[3:0] : hw_r;
    proto_cur = (pos_ext == FLEN_W'(PROTO_POS)) ? in_word.data_byte : proto_r;
    len_pos   = FLEN_W'(LEN_POS_BASE) + FLEN_W'({hw_cur, 2'b00});
    hi_hit    = (pos_ext == len_pos);
    lo_hit    = (pos_ext == len_pos + FLEN_W'(1));
    udp_cur   = {hi_hit ? in_word.data_byte : udp_r[15:8],
                 lo_hit ? in_word.data_byte : udp_r[7:0]};

    push_sum.frame_len    = pos_ext + FLEN_W'(1);
    push_sum.header_words = hw_cur;
    push_sum.protocol     = proto_cur;
    push_sum.udp_len      = udp_cur;
    push_sum.len_captured = cap_r | lo_hit;
    push                  = accept && in_word.last_byte;

    pos_nxt   = pos_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    udp_nxt   = udp_r;
    cap_nxt   = cap_r;
    if (accept) begin
      if (in_word.last_byte) begin
        pos_nxt   = '0;
        hw_nxt    = '0;
        proto_nxt = '0;
        udp_nxt   = '0;
        cap_nxt   = 1'b0;
      end else begin
        // position saturates one short of the maximum frame size
        if (pos_r != POS_W'(MAX_FRAME_BYTES - 1)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        hw_nxt    = hw_cur;
        proto_nxt = proto_cur;
        udp_nxt   = udp_cur;
        cap_nxt   = cap_r | lo_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      udp_r   <= '0;
      cap_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      udp_r   <= udp_nxt;
      cap_r   <= cap_nxt;
    end
  end

endmodule

@@ design/upl_queue.sv @@
module upl_queue import upl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_sum_t push_sum,
  input  logic       pop,
  output frame_sum_t pop_sum,
  output q_status_t  q_stat
);

  frame_sum_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  assign pop_sum      = mem[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/upl_back.sv @@
module upl_back import upl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_sum_t pop_sum,
  input  q_status_t  q_stat,
  output logic       pop,
  upl_out_if.source  out_word
);

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [PLEN_W-1:0]   plen_r, plen_nxt;

  logic [OFFSET_W-1:0] offset;
  logic [PLEN_W-1:0]   plen;
  logic [SUM_W-1:0]    payload_end;
  logic [STATUS_W-1:0] status;

  assign pop = !q_stat.empty && (!out_valid_r || out_word.ready);

  always_comb begin
    offset      = OFFSET_W'(PAYLOAD_BASE) + OFFSET_W'({pop_sum.header_words, 2'b00});
    plen        = pop_sum.udp_len - PLEN_W'(UDP_HDR);
    payload_end = SUM_W'(offset) + SUM_W'(plen);

    // checks in priority order
    if (pop_sum.frame_len < FLEN_W'(MIN_FRAME)) begin
      status = ST_TOO_SHORT;
    end else if (pop_sum.protocol != PROTO_UDP) begin
      status = ST_NOT_UDP;
    end else if (!pop_sum.len_captured) begin
      status = ST_BAD_LENGTH;
    end else if (pop_sum.udp_len <= 16'(UDP_HDR)) begin
      status = ST_NO_PAYLOAD;
    end else if (payload_end > SUM_W'(pop_sum.frame_len)) begin
      status = ST_BAD_LENGTH;
    end else begin
      status = ST_OK;
    end

    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    plen_nxt      = plen_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      status_nxt    = status;
      offset_nxt    = (status == ST_OK) ? offset : '0;
      plen_nxt      = (status == ST_OK) ? plen : '0;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.status         = status_r;
  assign out_word.payload_offset = offset_r;
  assign out_word.payload_len    = plen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    offset_r <= offset_nxt;
    plen_r   <= plen_nxt;
  end

endmodule
